// ----- src/planar_frame_transform_top_assert.svh -----
// Assertion macros for the planar frame transform. Clock clk, reset rst.
`ifndef PLANAR_FRAME_TRANSFORM_TOP_ASSERT_SVH
`define PLANAR_FRAME_TRANSFORM_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PFT_ASSERT_IMP(lbl, ante, cons, msg)
`define PFT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- src/pft_pkg.sv -----
`timescale 1ns / 1ps

package pft_pkg;

  localparam int COORD_W    = 32;
  localparam int HEAD_W     = 16;
  localparam int TRIG_W     = 16;
  localparam int TRIG_SHIFT = 14;

  // 33 bit difference, 49 bit products, 50 bit sums, 36 bit shifted, 37 bit result
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = DIFF_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SHIFT_W = SUM_W - TRIG_SHIFT;
  localparam int RES_W   = SHIFT_W + 1;

  localparam int DATA_W   = 2 * COORD_W + HEAD_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_ADDR_W-1:0] REG_BASE_X       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_Y       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_HEADING = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_SIN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_COS     = 3'd4;

  localparam logic signed [TRIG_W-1:0] COS_RESET    = 16'sd16384;
  localparam logic signed [HEAD_W-1:0] QUARTER_TURN = 16'sd16384;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    MODE_ULF_TO_GLOBAL = 2'd0,
    MODE_GLOBAL_TO_ULF = 2'd1,
    MODE_RUF_TO_GLOBAL = 2'd2,
    MODE_GLOBAL_TO_RUF = 2'd3
  } mode_t;

endpackage

// ----- src/planar_frame_transform_top.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: in_x, in_y, in_heading; tuser: mode
// m_*       out  m_tvalid/m_tready  tdata: out_x, out_y, out_heading; tuser: saturated
// cfg_*     in   cfg_we             cfg_addr selects register, cfg_data value
//
// One pose per cycle while the output is not stalled; an accepted beat passes the
// stage 1, 2 and 3 registers and then the output register before it can leave.
// Stages: operand select/subtract, four 33x16 multipliers, mode sums, base add
// and saturation. rst clears valid bits and loads register reset values.
// A stalled output holds its beat; empty stages still fill, so s_tready
// drops only when all four stages hold a beat and m_tready is low.

`include "planar_frame_transform_top_assert.svh"

module planar_frame_transform_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pft_pkg::DATA_W-1:0]        s_tdata,   // in_x, in_y, in_heading
  input  logic [pft_pkg::IN_USER_W-1:0]     s_tuser,   // mode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pft_pkg::DATA_W-1:0]        m_tdata,   // out_x, out_y, out_heading
  output logic [pft_pkg::OUT_USER_W-1:0]    m_tuser,   // saturated
  input  logic                              cfg_we,
  input  logic [pft_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pft_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import pft_pkg::*;

  logic signed [COORD_W-1:0] base_x;
  logic signed [COORD_W-1:0] base_y;
  logic signed [HEAD_W-1:0]  base_heading;
  logic signed [TRIG_W-1:0]  base_sin;
  logic signed [TRIG_W-1:0]  base_cos;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x       <= '0;
      base_y       <= '0;
      base_heading <= '0;
      base_sin     <= '0;
      base_cos     <= COS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BASE_X:       base_x       <= cfg_data;
        REG_BASE_Y:       base_y       <= cfg_data;
        REG_BASE_HEADING: base_heading <= cfg_data[HEAD_W-1:0];
        REG_BASE_SIN:     base_sin     <= cfg_data[TRIG_W-1:0];
        REG_BASE_COS:     base_cos     <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when its successor moves
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4      = !v4 || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: operands and heading
  mode_t                     in_mode;
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;
  logic signed [HEAD_W-1:0]  in_heading;
  logic                      in_l2g;
  logic signed [DIFF_W-1:0]  a_next;
  logic signed [DIFF_W-1:0]  b_next;
  logic signed [HEAD_W-1:0]  h_next;

  always_comb begin
    in_mode    = mode_t'(s_tuser[1:0]);
    in_x       = s_tdata[COORD_W-1:0];
    in_y       = s_tdata[2*COORD_W-1:COORD_W];
    in_heading = s_tdata[DATA_W-1:2*COORD_W];
    in_l2g     = (in_mode == MODE_ULF_TO_GLOBAL) || (in_mode == MODE_RUF_TO_GLOBAL);
    if (in_l2g) begin
      a_next = DIFF_W'(in_x);
      b_next = DIFF_W'(in_y);
    end else begin
      a_next = DIFF_W'(in_x) - DIFF_W'(base_x);
      b_next = DIFF_W'(in_y) - DIFF_W'(base_y);
    end
    unique case (in_mode)
      MODE_ULF_TO_GLOBAL: h_next = in_heading + base_heading;
      MODE_GLOBAL_TO_ULF: h_next = in_heading - base_heading;
      MODE_RUF_TO_GLOBAL: h_next = in_heading + base_heading - QUARTER_TURN;
      MODE_GLOBAL_TO_RUF: h_next = QUARTER_TURN + in_heading - base_heading;
      default:            h_next = in_heading;
    endcase
  end

  mode_t                    s1_mode;
  logic signed [DIFF_W-1:0] s1_a;
  logic signed [DIFF_W-1:0] s1_b;
  logic signed [HEAD_W-1:0] s1_h;

  always_ff @(posedge clk) begin
    if (en1 && s_tvalid) begin
      s1_mode <= in_mode;
      s1_a    <= a_next;
      s1_b    <= b_next;
      s1_h    <= h_next;
    end
  end

  // stage 2: products
  mode_t                    s2_mode;
  logic signed [PROD_W-1:0] s2_ac;
  logic signed [PROD_W-1:0] s2_bs;
  logic signed [PROD_W-1:0] s2_as;
  logic signed [PROD_W-1:0] s2_bc;
  logic signed [HEAD_W-1:0] s2_h;

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_mode <= s1_mode;
      s2_ac   <= s1_a * base_cos;
      s2_bs   <= s1_b * base_sin;
      s2_as   <= s1_a * base_sin;
      s2_bc   <= s1_b * base_cos;
      s2_h    <= s1_h;
    end
  end

  // stage 3: per-mode sums
  logic signed [SUM_W-1:0] x_sum_next;
  logic signed [SUM_W-1:0] y_sum_next;

  always_comb begin
    unique case (s2_mode)
      MODE_ULF_TO_GLOBAL: begin
        x_sum_next = SUM_W'(s2_ac) - SUM_W'(s2_bs);
        y_sum_next = SUM_W'(s2_as) + SUM_W'(s2_bc);
      end
      MODE_GLOBAL_TO_ULF: begin
        x_sum_next = SUM_W'(s2_ac) + SUM_W'(s2_bs);
        y_sum_next = SUM_W'(s2_bc) - SUM_W'(s2_as);
      end
      MODE_RUF_TO_GLOBAL: begin
        x_sum_next = SUM_W'(s2_as) + SUM_W'(s2_bc);
        y_sum_next = SUM_W'(s2_bs) - SUM_W'(s2_ac);
      end
      MODE_GLOBAL_TO_RUF: begin
        x_sum_next = SUM_W'(s2_as) - SUM_W'(s2_bc);
        y_sum_next = SUM_W'(s2_ac) + SUM_W'(s2_bs);
      end
      default: begin
        x_sum_next = '0;
        y_sum_next = '0;
      end
    endcase
  end

  logic                     s3_l2g;
  logic signed [SUM_W-1:0]  s3_x;
  logic signed [SUM_W-1:0]  s3_y;
  logic signed [HEAD_W-1:0] s3_h;

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3_l2g <= (s2_mode == MODE_ULF_TO_GLOBAL) || (s2_mode == MODE_RUF_TO_GLOBAL);
      s3_x   <= x_sum_next;
      s3_y   <= y_sum_next;
      s3_h   <= s2_h;
    end
  end

  // stage 4: floor shift, base add, saturate
  logic signed [SHIFT_W-1:0] x_sh;
  logic signed [SHIFT_W-1:0] y_sh;
  logic signed [RES_W-1:0]   x_full;
  logic signed [RES_W-1:0]   y_full;
  logic                      x_fits;
  logic                      y_fits;
  logic signed [COORD_W-1:0] x_next;
  logic signed [COORD_W-1:0] y_next;

  always_comb begin
    x_sh = $signed(s3_x[SUM_W-1:TRIG_SHIFT]);
    y_sh = $signed(s3_y[SUM_W-1:TRIG_SHIFT]);
    x_full = RES_W'(x_sh) + (s3_l2g ? RES_W'(base_x) : RES_W'(0));
    y_full = RES_W'(y_sh) + (s3_l2g ? RES_W'(base_y) : RES_W'(0));
    x_fits = (&x_full[RES_W-1:COORD_W-1]) || !(|x_full[RES_W-1:COORD_W-1]);
    y_fits = (&y_full[RES_W-1:COORD_W-1]) || !(|y_full[RES_W-1:COORD_W-1]);
    if (x_fits) x_next = x_full[COORD_W-1:0];
    else        x_next = x_full[RES_W-1] ? COORD_MIN : COORD_MAX;
    if (y_fits) y_next = y_full[COORD_W-1:0];
    else        y_next = y_full[RES_W-1] ? COORD_MIN : COORD_MAX;
  end

  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [HEAD_W-1:0]  out_heading;
  logic                      saturated;

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      out_x       <= x_next;
      out_y       <= y_next;
      out_heading <= s3_h;
      saturated   <= !(x_fits && y_fits);
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {out_heading, out_y, out_x};
  assign m_tuser  = saturated;

  `PFT_ASSERT_IMP(a_stall_only_on_output, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")
  `PFT_ASSERT_IMP(a_sat_at_limit, m_tvalid && m_tuser[0], (out_x == COORD_MAX) || (out_x == COORD_MIN) || (out_y == COORD_MAX) || (out_y == COORD_MIN), "saturated flag without clipped coordinate")
  `PFT_ASSERT_NXT(a_latency, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready, m_tvalid, "accepted beat did not reach output in four cycles")

endmodule

// ----- tb/tb_planar_frame_transform_top.sv -----
`timescale 1ns / 1ps

module tb_planar_frame_transform_top;
  import pft_pkg::*;

  localparam int PIPE_DEPTH      = 4;
  localparam int IDLE_LIMIT      = 2000;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 122;
  localparam int PRINT_CAP       = 50;
  localparam int NUM_ROWS        = 23;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [HEAD_W-1:0]  heading;
    logic                      sat;
  } pose_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [HEAD_W-1:0]  heading;
    logic signed [TRIG_W-1:0]  sin_q14;
    logic signed [TRIG_W-1:0]  cos_q14;
  } base_pose_t;

  typedef struct packed {
    mode_t               mode;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [HEAD_W-1:0]   heading;
    logic                extreme_base;  // run under EXTREME_A instead of reset values
    logic                typed;         // want holds the expected beat
    pose_t               want;
  } pose_row_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_style_t;

  localparam base_pose_t EXTREME_A = '{COORD_MAX, COORD_MIN, 16'sh8000, 16'sh8000, 16'sh8000};
  localparam base_pose_t EXTREME_B = '{COORD_MIN, COORD_MAX, 16'sh7FFF, 16'sd16384,
                                       -16'sd16384};
  localparam base_pose_t QUARTER_B = '{32'sd1024, -32'sd2048, 16'sd16384, 16'sd16384, 16'sd0};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [DATA_W-1:0]       s_tdata = '0;     // in_x, in_y, in_heading
  logic [IN_USER_W-1:0]    s_tuser = '0;     // mode
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [DATA_W-1:0]       m_tdata;          // out_x, out_y, out_heading
  logic [OUT_USER_W-1:0]   m_tuser;          // saturated
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  logic signed [COORD_W-1:0] cur_base_x = '0;
  logic signed [COORD_W-1:0] cur_base_y = '0;
  logic signed [HEAD_W-1:0]  cur_base_heading = '0;
  logic signed [TRIG_W-1:0]  cur_base_sin = '0;
  logic signed [TRIG_W-1:0]  cur_base_cos = COS_RESET;

  pose_t     expected_poses[$];
  int        mismatch_count = 0;
  int        burst_left = 0;
  int        idle_cycles = 0;
  int        beat_count = 0;
  logic [7:0] rx_tick = '0;
  rx_style_t rx_style = RX_ALWAYS;

  pose_row_t pose_rows [NUM_ROWS] = '{
    '{MODE_ULF_TO_GLOBAL, 32'sd0, 32'sd0, 16'sd0, 1'b0, 1'b1,
      '{32'sd0, 32'sd0, 16'sd0, 1'b0}},
    '{MODE_ULF_TO_GLOBAL, COORD_MAX, COORD_MIN, 16'sh7FFF, 1'b0, 1'b1,
      '{COORD_MAX, COORD_MIN, 16'sh7FFF, 1'b0}},
    '{MODE_GLOBAL_TO_ULF, COORD_MIN, COORD_MAX, 16'sh8000, 1'b0, 1'b1,
      '{COORD_MIN, COORD_MAX, 16'sh8000, 1'b0}},
    '{MODE_RUF_TO_GLOBAL, COORD_MIN, 32'sd5, 16'sd0, 1'b0, 1'b1,
      '{32'sd5, COORD_MAX, -16'sd16384, 1'b1}},
    '{MODE_GLOBAL_TO_RUF, 32'sd7, COORD_MIN, 16'sh8000, 1'b0, 1'b1,
      '{COORD_MAX, 32'sd7, -16'sd16384, 1'b1}},
    '{MODE_RUF_TO_GLOBAL, 32'sd1, 32'sd2, -16'sd16384, 1'b0, 1'b1,
      '{32'sd2, -32'sd1, 16'sh8000, 1'b0}},
    '{MODE_GLOBAL_TO_RUF, -32'sd1, 32'sd3, 16'sd16384, 1'b0, 1'b1,
      '{-32'sd3, -32'sd1, 16'sh8000, 1'b0}},
    '{MODE_GLOBAL_TO_ULF, COORD_MAX, COORD_MIN, 16'sd0, 1'b0, 1'b1,
      '{COORD_MAX, COORD_MIN, 16'sd0, 1'b0}},
    '{MODE_RUF_TO_GLOBAL, COORD_MAX, COORD_MIN, 16'sh7FFF, 1'b0, 1'b1,
      '{COORD_MIN, -32'sd2147483647, 16'sd16383, 1'b0}},
    '{MODE_GLOBAL_TO_RUF, COORD_MIN, COORD_MIN, 16'sd16384, 1'b0, 1'b1,
      '{COORD_MAX, COORD_MIN, 16'sh8000, 1'b1}},
    '{MODE_ULF_TO_GLOBAL, -32'sd1, -32'sd1, -16'sd1, 1'b0, 1'b1,
      '{-32'sd1, -32'sd1, -16'sd1, 1'b0}},
    '{MODE_GLOBAL_TO_ULF, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 1'b0, 1'b0, '0},
    '{MODE_RUF_TO_GLOBAL, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 1'b0, 1'b0, '0},
    '{MODE_ULF_TO_GLOBAL, COORD_MAX, COORD_MAX, 16'sh7FFF, 1'b1, 1'b0, '0},
    '{MODE_ULF_TO_GLOBAL, COORD_MIN, COORD_MIN, 16'sh8000, 1'b1, 1'b0, '0},
    '{MODE_GLOBAL_TO_ULF, COORD_MIN, COORD_MAX, 16'sd0, 1'b1, 1'b0, '0},
    '{MODE_GLOBAL_TO_ULF, COORD_MAX, COORD_MIN, 16'sd1, 1'b1, 1'b0, '0},
    '{MODE_RUF_TO_GLOBAL, COORD_MAX, COORD_MIN, 16'hFFFF, 1'b1, 1'b0, '0},
    '{MODE_RUF_TO_GLOBAL, COORD_MIN, COORD_MAX, 16'sd0, 1'b1, 1'b0, '0},
    '{MODE_GLOBAL_TO_RUF, COORD_MIN, COORD_MAX, 16'sd16384, 1'b1, 1'b0, '0},
    '{MODE_GLOBAL_TO_RUF, COORD_MAX, COORD_MIN, 16'hC000, 1'b1, 1'b0, '0},
    '{MODE_GLOBAL_TO_ULF, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 1'b1, 1'b0, '0},
    '{MODE_GLOBAL_TO_RUF, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 1'b1, 1'b0, '0}
  };

  planar_frame_transform_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v, inout logic clip);
    if (v > longint'(COORD_MAX)) begin
      clip = 1'b1;
      return COORD_MAX;
    end
    if (v < longint'(COORD_MIN)) begin
      clip = 1'b1;
      return COORD_MIN;
    end
    return v[COORD_W-1:0];
  endfunction

  // Rotate and translate one pose with the current base; >>> on longint floors.
  function automatic pose_t transform_pose(mode_t mode, logic signed [COORD_W-1:0] px,
                                           logic signed [COORD_W-1:0] py,
                                           logic signed [HEAD_W-1:0] ph);
    longint lx, ly, bx, by, dx, dy, s, c, rx, ry;
    logic   clip;
    pose_t  r;
    lx = px;
    ly = py;
    bx = cur_base_x;
    by = cur_base_y;
    s  = cur_base_sin;
    c  = cur_base_cos;
    dx = lx - bx;
    dy = ly - by;
    clip = 1'b0;
    case (mode)
      MODE_ULF_TO_GLOBAL: begin
        rx = bx + ((lx * c - ly * s) >>> TRIG_SHIFT);
        ry = by + ((lx * s + ly * c) >>> TRIG_SHIFT);
        r.heading = ph + cur_base_heading;
      end
      MODE_GLOBAL_TO_ULF: begin
        rx = (dx * c + dy * s) >>> TRIG_SHIFT;
        ry = (dy * c - dx * s) >>> TRIG_SHIFT;
        r.heading = ph - cur_base_heading;
      end
      MODE_RUF_TO_GLOBAL: begin
        rx = bx + ((s * lx + c * ly) >>> TRIG_SHIFT);
        ry = by + ((s * ly - c * lx) >>> TRIG_SHIFT);
        r.heading = ph + cur_base_heading - QUARTER_TURN;
      end
      default: begin
        rx = (s * dx - c * dy) >>> TRIG_SHIFT;
        ry = (c * dx + s * dy) >>> TRIG_SHIFT;
        r.heading = QUARTER_TURN + ph - cur_base_heading;
      end
    endcase
    r.x = clamp_coord(rx, clip);
    r.y = clamp_coord(ry, clip);
    r.sat = clip;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3:    return 32'($urandom_range(0, 1 << 20) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TRIG_W-1:0] pick_trig();
    case ($urandom_range(0, 7))
      0:       return -16'sd16384;
      1:       return 16'sd16384;
      2:       return 16'sh8000;
      3:       return 16'sd0;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  task automatic report_error(string msg);
    if (mismatch_count < PRINT_CAP)
      $display("ERROR %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    case (addr)
      REG_BASE_X:       cur_base_x = data;
      REG_BASE_Y:       cur_base_y = data;
      REG_BASE_HEADING: cur_base_heading = data[HEAD_W-1:0];
      REG_BASE_SIN:     cur_base_sin = data[TRIG_W-1:0];
      REG_BASE_COS:     cur_base_cos = data[TRIG_W-1:0];
      default: ;
    endcase
  endtask

  // Keep cfg_we high across the burst of writes; junk in the upper bits must be ignored.
  task automatic load_base(base_pose_t b);
    write_reg(REG_BASE_X, b.x);
    write_reg(REG_BASE_Y, b.y);
    write_reg(REG_BASE_HEADING, {16'($urandom), b.heading});
    write_reg(REG_BASE_SIN, {16'($urandom), b.sin_q14});
    write_reg(REG_BASE_COS, {16'($urandom), b.cos_q14});
    write_reg(CFG_ADDR_W'($urandom_range(2 ** CFG_ADDR_W - 1, REG_BASE_COS + 1)), $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pose(mode_t mode, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [HEAD_W-1:0] h, logic typed, pose_t want);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {h, y, x};
    s_tuser  <= mode;
    do @(posedge clk); while (!s_tready);
    expected_poses.push_back(typed ? want : transform_pose(mode, x, y, h));
    burst_left--;
    if (burst_left == 0)
      s_tvalid <= 1'b0;
  endtask

  // Drop valid, wait until every expected pose has been checked, then let the clock run idle.
  task automatic drain_pipe();
    if (burst_left != 0)
      s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick == 8'd0)
      rx_style <= rx_style_t'($urandom_range(0, 3));
    case (rx_style)
      RX_ALWAYS:   m_tready <= 1'b1;
      RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   m_tready <= (rx_tick[1:0] == 2'd0);
      RX_PERIODIC: m_tready <= (rx_tick[2:0] < 3'd5);
    endcase
  end

  always @(posedge clk) begin : check_beat
    pose_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W],
             m_tdata[DATA_W-1:2*COORD_W], m_tuser[0]};
      if (expected_poses.size() == 0) begin
        report_error($sformatf("beat %0d arrived with nothing expected", beat_count));
      end else begin
        want = expected_poses.pop_front();
        if (got.x !== want.x)
          report_error($sformatf("beat %0d out_x %0d, expected %0d",
                                 beat_count, got.x, want.x));
        if (got.y !== want.y)
          report_error($sformatf("beat %0d out_y %0d, expected %0d",
                                 beat_count, got.y, want.y));
        if (got.heading !== want.heading)
          report_error($sformatf("beat %0d out_heading %0d, expected %0d",
                                 beat_count, got.heading, want.heading));
        if (got.sat !== want.sat)
          report_error($sformatf("beat %0d saturated %b, expected %b",
                                 beat_count, got.sat, want.sat));
      end
      beat_count++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("planar_frame_transform_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    base_pose_t base;
    logic       extreme_loaded;
    extreme_loaded = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rows checked against typed values run on the reset base.
    foreach (pose_rows[i]) begin
      if (pose_rows[i].extreme_base && !extreme_loaded) begin
        drain_pipe();
        load_base(EXTREME_A);
        extreme_loaded = 1'b1;
      end
      send_pose(pose_rows[i].mode, pose_rows[i].x, pose_rows[i].y, pose_rows[i].heading,
                pose_rows[i].typed, pose_rows[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_pipe();
      if (p == 0)
        base = EXTREME_B;
      else if (p == 1)
        base = QUARTER_B;
      else
        base = '{pick_coord(), pick_coord(), 16'($urandom), pick_trig(), pick_trig()};
      load_base(base);
      repeat (ITEMS_PER_PHASE)
        send_pose(mode_t'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                  16'($urandom), 1'b0, '0);
    end

    drain_pipe();
    if (mismatch_count == 0)
      $display("planar_frame_transform_top test passed");
    else
      $display("planar_frame_transform_top test failed");
    $finish;
  end

endmodule
